@@ rtl/itar_pkg.sv @@
// shared types, character codes and digit mapping for the integer to ascii block
package itar_pkg;

    localparam logic [7:0] RADIX_MIN    = 8'd2;
    localparam logic [7:0] RADIX_MAX    = 8'd36;
    localparam logic [7:0] RADIX_SIGNED = 8'd10;

    localparam logic [6:0] CHAR_NUL   = 7'h00;
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_ALPHA = 7'h57;
    localparam logic [5:0] DIGIT_TEN  = 6'd10;

    typedef struct packed {
        logic       invalid;
        logic       negative;
        logic [5:0] radix;
    } cmd_flags_t;

    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] res;
        if (d < DIGIT_TEN) begin
            res = CHAR_ZERO + {1'b0, d};
        end else begin
            res = CHAR_ALPHA + {1'b0, d};
        end
        return res;
    endfunction

endpackage

@@ rtl/itar_front.sv @@
// front end: accepts input transfers, classifies radix and sign, forms the magnitude
module itar_front #(
    parameter int WORD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [15:0]     s_number,
    input  logic        [7:0]      s_radix,
    input  logic                   q_full,
    output logic                   q_push,
    output itar_pkg::cmd_flags_t   q_flags,
    output logic [WORD_BITS-1:0]   q_value
);
    import itar_pkg::*;

    logic [31:0]          number_ext;
    logic [WORD_BITS-1:0] word;
    logic                 radix_bad;
    logic                 is_negative;

    always_comb begin
        number_ext  = {{16{s_number[15]}}, s_number};
        word        = number_ext[WORD_BITS-1:0];
        radix_bad   = (s_radix < RADIX_MIN) || (s_radix > RADIX_MAX);
        is_negative = !radix_bad && (s_radix == RADIX_SIGNED) && word[WORD_BITS-1];
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_flags.invalid  = radix_bad;
        q_flags.negative = is_negative;
        q_flags.radix    = s_radix[5:0];
        // the most negative word wraps to its own unsigned magnitude
        q_value          = is_negative ? (~word + {{(WORD_BITS-1){1'b0}}, 1'b1}) : word;
    end

    // a transfer is never taken with the queue full
    assert property (@(posedge aclk) disable iff (!aresetn) q_full |-> !q_push)
        else $error("push while queue full");
    // a negative flag only goes with radix ten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_flags.negative) |-> (s_radix == RADIX_SIGNED))
        else $error("negative flag outside radix ten");
    // an invalid command carries no sign
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_flags.invalid) |-> !q_flags.negative)
        else $error("invalid command marked negative");

endmodule

@@ rtl/itar_fifo.sv @@
// two entry command queue between front and back
module itar_fifo #(
    parameter int WORD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  itar_pkg::cmd_flags_t   push_flags,
    input  logic [WORD_BITS-1:0]   push_value,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output itar_pkg::cmd_flags_t   pop_flags,
    output logic [WORD_BITS-1:0]   pop_value
);
    import itar_pkg::*;

    cmd_flags_t           flags_mem [2];
    logic [WORD_BITS-1:0] value_mem [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_pop    = pop && not_empty;
    assign pop_flags = flags_mem[rd_ptr_reg];
    assign pop_value = value_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            flags_mem[wr_ptr_reg] <= push_flags;
            value_mem[wr_ptr_reg] <= push_value;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !do_pop && count_reg == 2'd1) |=> full)
        else $error("queue did not fill");

endmodule

@@ rtl/itar_back.sv @@
// back end: bit serial divider, digit stack and character emitter
module itar_back #(
    parameter int WORD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_not_empty,
    output logic                   q_pop,
    input  itar_pkg::cmd_flags_t   q_flags,
    input  logic [WORD_BITS-1:0]   q_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [6:0]             m_character,
    output logic                   m_last_char
);
    import itar_pkg::*;

    localparam int IDX_BITS = $clog2(WORD_BITS);
    localparam int SP_BITS  = $clog2(WORD_BITS + 1);
    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_TOP = CNT_BITS'(WORD_BITS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SIGN = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_TERM = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [WORD_BITS-1:0] quot_reg, quot_next;
    logic [5:0]           rem_reg, rem_next;
    logic [5:0]           radix_reg, radix_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [SP_BITS-1:0]   sp_reg, sp_next;
    logic [5:0]           stack [WORD_BITS];
    logic                 out_valid_reg, out_valid_next;
    logic [6:0]           char_reg, char_next;
    logic                 last_reg, last_next;

    logic                 slot_free;
    logic [6:0]           rem_shift;
    logic                 qbit;
    logic [5:0]           rem_step;
    logic [WORD_BITS-1:0] quot_step;
    logic [SP_BITS-1:0]   sp_dec;
    logic                 push_digit;

    assign slot_free   = !out_valid_reg || m_ready;
    assign m_valid     = out_valid_reg;
    assign m_character = char_reg;
    assign m_last_char = last_reg;
    assign sp_dec      = sp_reg - SP_BITS'(1);

    // one restoring division step per cycle
    always_comb begin
        rem_shift = {rem_reg, quot_reg[WORD_BITS-1]};
        qbit      = (rem_shift >= {1'b0, radix_reg});
        rem_step  = qbit ? 6'(rem_shift - {1'b0, radix_reg}) : rem_shift[5:0];
        quot_step = {quot_reg[WORD_BITS-2:0], qbit};
    end

    always_comb begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        cnt_next       = cnt_reg;
        sp_next        = sp_reg;
        out_valid_next = out_valid_reg && !m_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        push_digit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    quot_next  = q_value;
                    radix_next = q_flags.radix;
                    rem_next   = 6'd0;
                    cnt_next   = CNT_TOP;
                    sp_next    = '0;
                    priority if (q_flags.invalid) begin
                        state_next = ST_TERM;
                    end else if (q_flags.negative) begin
                        state_next = ST_SIGN;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV: begin
                quot_next = quot_step;
                rem_next  = rem_step;
                cnt_next  = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0) begin
                    // digit done: stack the remainder, go again on a nonzero quotient
                    push_digit = 1'b1;
                    sp_next    = sp_reg + SP_BITS'(1);
                    rem_next   = 6'd0;
                    cnt_next   = CNT_TOP;
                    if (quot_step == '0) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(stack[sp_dec[IDX_BITS-1:0]]);
                    last_next      = 1'b0;
                    sp_next        = sp_dec;
                    if (sp_dec == '0) begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_TERM: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_NUL;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        cnt_reg   <= cnt_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        if (push_digit) begin
            stack[sp_reg[IDX_BITS-1:0]] <= rem_step;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_BITS'(WORD_BITS))
        else $error("digit stack overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (sp_reg != '0))
        else $error("emit with empty digit stack");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < radix_reg))
        else $error("partial remainder not below radix");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TERM && slot_free) |=> (state_reg == ST_IDLE && last_reg))
        else $error("terminator not issued");

endmodule

@@ rtl/integer_to_ascii_radix.sv @@
// top level of the integer to ascii converter, radix 2 to 36
//
// input channel s_*: one transfer carries a signed 16 bit s_number and an
// 8 bit s_radix. result channel m_*: one transfer per character, most
// significant digit first, then a zero character with m_last_char high.
// radix 10 prints a leading '-' for negative words; other radices print the
// unsigned WORD_BITS pattern; a radix outside 2..36 gives only the terminator.
// the front classifies each transfer and writes a two entry command queue,
// so up to two items are taken while the back is still busy.
// the back divides bit serially: each digit takes a full pass over all
// WORD_BITS quotient bits, and that divider loop sets the rate. a minus sign
// is emitted after the item is taken from the queue and before the division;
// the digits follow once all of them are stacked, and the back takes the next
// item from the queue only after the terminator.
// when m_ready is low the output register holds its character and the back
// waits before its next character, though a division in progress goes on;
// the queue keeps accepting until it is full.
// reset (aresetn low, synchronous) empties the queue and the output register.
module integer_to_ascii_radix #(
    parameter int WORD_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_number,
    input  logic        [7:0]  s_radix,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [6:0]  m_character,
    output logic               m_last_char
);
    import itar_pkg::*;

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_not_empty;
    cmd_flags_t           push_flags;
    cmd_flags_t           pop_flags;
    logic [WORD_BITS-1:0] push_value;
    logic [WORD_BITS-1:0] pop_value;

    itar_front #(.WORD_BITS(WORD_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_number (s_number),
        .s_radix  (s_radix),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_flags  (push_flags),
        .q_value  (push_value)
    );

    itar_fifo #(.WORD_BITS(WORD_BITS)) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_flags (push_flags),
        .push_value (push_value),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .pop_flags  (pop_flags),
        .pop_value  (pop_value)
    );

    itar_back #(.WORD_BITS(WORD_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .q_flags     (pop_flags),
        .q_value     (pop_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char)
    );

endmodule
